// ===== sv/teq_pkg.sv =====
`default_nettype none
package teq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int SLOT_COUNT  = 64;
   localparam int ADDR_W      = $clog2(SLOT_COUNT);
   localparam int CNT_W       = $clog2(SLOT_COUNT + 1);

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic ST_RELEASED = 1'b0;
   localparam logic ST_REJECTED = 1'b1;

   typedef struct packed {
      logic        op;
      logic [15:0] event_id;
      logic [1:0]  event_kind;
      logic [31:0] time_value;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [15:0] out_id;
      logic [1:0]  out_kind;
      logic [31:0] out_time;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] due;
      logic [15:0] id;
      logic [1:0]  kind;
   } entry_type;

   typedef struct packed {
      logic latch;
      logic reject;
      logic add_rd;
      logic add_shift;
      logic add_put;
      logic tick_rd;
      logic tick_take;
      logic tick_fin;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic pos_zero;
      logic due_le;
   } stat_type;

endpackage
`default_nettype wire

// ===== sv/timer_event_queue_core.sv =====
`default_nettype none
// Timer event queue: events kept sorted by due time, earliest first, ties in
// arrival order, in a ring memory of QUEUE_DEPTH entries.
// Input: a beat on req_beat is taken at a rising edge with start high and busy
// low. op add stores an event; op tick releases every event due at or before
// the carried time.
// Output: each result is on rsp_beat for exactly one cycle with rsp_valid high;
// the receiver cannot stall, so results are never held back.
// Timing: an add to a full queue answers the cycle after acceptance and keeps
// busy low. An add that inserts behind later entries keeps busy high while it
// moves each of them up one slot; each shifted entry costs one memory read and
// one memory write, done in separate states.
// A tick keeps busy high while it releases due events one at a time; the last
// one is marked last and shown in the cycle in which busy falls. A tick with
// nothing due gives no result.
// Reset (synchronous, active high) empties the queue at once; no clearing
// pass is needed because only slots below the entry count are ever read.
module timer_event_queue_core
   import teq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_beat,
   output logic         rsp_valid,
   output rsp_type      rsp_beat
);

   cmd_type  cmd;
   stat_type stat;

   teq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_beat.op),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   teq_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_beat  (req_beat),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_beat  (rsp_beat)
   );

endmodule
`default_nettype wire

// ===== sv/teq_ctrl.sv =====
`default_nettype none
module teq_ctrl
   import teq_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire logic     req_op,
   input  wire stat_type stat,
   output cmd_type       cmd,
   output logic          busy
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_A_CHK = 3'd1;
   localparam logic [2:0] S_A_CMP = 3'd2;
   localparam logic [2:0] S_T_RD  = 3'd3;
   localparam logic [2:0] S_T_CMP = 3'd4;
   localparam logic [2:0] S_T_FIN = 3'd5;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               if (req_op == OP_ADD) begin
                  if (stat.full) begin
                     cmd.reject = 1'b1;
                  end else begin
                     state_in = S_A_CHK;
                  end
               end else begin
                  state_in = S_T_RD;
               end
            end
         end
         S_A_CHK: begin
            if (stat.pos_zero) begin
               cmd.add_put = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.add_rd = 1'b1;
               state_in   = S_A_CMP;
            end
         end
         S_A_CMP: begin
            // A later due time moves up one slot; otherwise the new event goes here.
            if (!stat.due_le) begin
               cmd.add_shift = 1'b1;
               state_in      = S_A_CHK;
            end else begin
               cmd.add_put = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_T_RD: begin
            if (stat.empty) begin
               state_in = S_T_FIN;
            end else begin
               cmd.tick_rd = 1'b1;
               state_in    = S_T_CMP;
            end
         end
         S_T_CMP: begin
            if (stat.due_le) begin
               cmd.tick_take = 1'b1;
               state_in      = S_T_RD;
            end else begin
               state_in = S_T_FIN;
            end
         end
         S_T_FIN: begin
            cmd.tick_fin = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/teq_dpath.sv =====
`default_nettype none
module teq_dpath
   import teq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_beat,
   input  wire cmd_type cmd,
   output stat_type     stat,
   output logic         rsp_valid,
   output rsp_type      rsp_beat
);

   entry_type mem [SLOT_COUNT];

   req_type          req_ff;
   entry_type        rd_ff;
   entry_type        pend_ff, pend_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [ADDR_W-1:0] pos_addr;
   logic [ADDR_W-1:0] prev_addr;
   logic              wr_en;
   entry_type         wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   entry_type         new_entry;

   assign pos_addr  = head_ff + pos_ff[ADDR_W-1:0];
   assign prev_addr = pos_addr - ADDR_W'(1);

   assign new_entry = '{due: req_ff.time_value, id: req_ff.event_id, kind: req_ff.event_kind};

   assign stat.full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.empty    = (count_ff == '0);
   assign stat.pos_zero = (pos_ff == '0);
   assign stat.due_le   = (rd_ff.due <= req_ff.time_value);

   assign wr_en   = cmd.add_shift | cmd.add_put;
   assign wr_data = cmd.add_shift ? rd_ff : new_entry;
   assign rd_en   = cmd.add_rd | cmd.tick_rd;
   assign rd_addr = cmd.add_rd ? prev_addr : head_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[pos_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
      if (cmd.latch) begin
         req_ff <= req_beat;
      end
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
      pos_ff  <= pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = 1'b0;

      if (cmd.latch) begin
         pos_in = count_ff;
      end
      if (cmd.reject) begin
         rsp_valid_in    = 1'b1;
         rsp_in.status   = ST_REJECTED;
         rsp_in.out_id   = req_beat.event_id;
         rsp_in.out_kind = req_beat.event_kind;
         rsp_in.out_time = req_beat.time_value;
         rsp_in.last     = 1'b1;
      end
      if (cmd.add_shift) begin
         pos_in = pos_ff - CNT_W'(1);
      end
      if (cmd.add_put) begin
         count_in = count_ff + CNT_W'(1);
      end
      // A released event is held in pend_ff until the next take or the finish, so that the final one can carry last.
      if (cmd.tick_take) begin
         head_in       = head_ff + ADDR_W'(1);
         count_in      = count_ff - CNT_W'(1);
         pend_in       = rd_ff;
         pend_valid_in = 1'b1;
      end
      if ((cmd.tick_take || cmd.tick_fin) && pend_valid_ff) begin
         rsp_valid_in    = 1'b1;
         rsp_in.status   = ST_RELEASED;
         rsp_in.out_id   = pend_ff.id;
         rsp_in.out_kind = pend_ff.kind;
         rsp_in.out_time = pend_ff.due;
         rsp_in.last     = cmd.tick_fin;
      end
      if (cmd.tick_fin) begin
         pend_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule
`default_nettype wire
